// ===== rtl/krt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants for the keyed rate table
// Request and response transactions, table entry layout, status codes,
// sequencer states and the command structs between the submodules.
// ----------------------------------------------------------------------------
package krt_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // Transaction kinds
   localparam logic [1:0] KIND_UPSERT  = 2'd0;
   localparam logic [1:0] KIND_FIND    = 2'd1;
   localparam logic [1:0] KIND_CONVERT = 2'd2;

   // Saturation limits of a signed 48-bit result
   localparam logic [47:0] SAT_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SAT_MIN = 48'h8000_0000_0000;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_INVALID   = 3'd1,
      STATUS_STALE     = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_MUL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [23:0]        base_code;
      logic [23:0]        quote_code;
      logic signed [47:0] rate_value;
      logic [47:0]        event_time;
      logic signed [47:0] amount;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [47:0] converted_amount;
      logic signed [47:0] record_rate;
      logic [47:0]        record_time;
      logic [31:0]        revision_number;
      logic [CNT_W-1:0]   entry_count;
   } rsp_type;

   typedef struct packed {
      logic [23:0]        base_code;
      logic [23:0]        quote_code;
      logic signed [47:0] rate_value;
      logic [47:0]        event_time;
   } entry_type;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } store_cmd_type;

   typedef struct packed {
      logic               start;
      logic signed [47:0] amount;
      logic signed [47:0] rate_value;
   } mul_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [47:0] value;
   } mul_rsp_type;

endpackage
`default_nettype wire

// ===== rtl/keyed_rate_table_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_rate_table_convert: currency pair rate table with conversion
// Holds up to CAPACITY (base, quote) pairs with a rate and an event time,
// serves upsert, find and convert transactions, one response each.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_stall   krt_pkg::req_type
//   rsp_      out        rsp_valid/rsp_stall   krt_pkg::rsp_type
//
// Flow: one transaction at a time; req_stall stays high from acceptance until
//   the response register loads, after a table walk over the used entries where
//   a lookup is needed, and after the scaler for a convert that finds its pair.
// Reset: clears the entry count to zero and the revision to one; table
//   contents stay as they are and are never read beyond the entry count.
// Stalls: hold the response while rsp_stall is high; the next one proceeds.
//
module keyed_rate_table_convert (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  krt_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output krt_pkg::rsp_type  rsp_payload
);

   // table port commands and read data
   krt_pkg::store_cmd_type store_cmd;
   krt_pkg::entry_type     rd_data;

   // scaler start and result
   krt_pkg::mul_cmd_type   mul_cmd;
   krt_pkg::mul_rsp_type   mul_rsp;

   // Sequencer: owns the counters, the scan and the response register.
   krt_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .store_cmd   (store_cmd),
      .rd_data     (rd_data),
      .mul_cmd     (mul_cmd),
      .mul_rsp     (mul_rsp)
   );

   // Table storage: entries are appended in order, never removed.
   krt_store u_store (
      .clock     (clock),
      .store_cmd (store_cmd),
      .rd_data   (rd_data)
   );

   // Scaler: amount times rate, rounded and saturated.
   krt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_cmd (mul_cmd),
      .mul_rsp (mul_rsp)
   );

endmodule
`default_nettype wire

// ===== rtl/krt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_store: rate table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krt_store (
   input  wire                    clock,
   input  krt_pkg::store_cmd_type store_cmd,
   output krt_pkg::entry_type     rd_data
);

   krt_pkg::entry_type mem_ff [krt_pkg::CAPACITY];
   krt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (store_cmd.wr_en) begin
         mem_ff[store_cmd.wr_addr] <= store_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (store_cmd.rd_en) begin
         rd_data_ff <= mem_ff[store_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/krt_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_mul: iterative fixed-point scaler
// Multiplies magnitudes with one 24x24 multiplier over four passes, then
// rounds, restores the sign and saturates to 48 bits.
// ----------------------------------------------------------------------------
module krt_mul (
   input  wire                  clock,
   input  wire                  reset,
   input  krt_pkg::mul_cmd_type mul_cmd,
   output krt_pkg::mul_rsp_type mul_rsp
);

   logic        run_ff,  run_in;
   logic [2:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic        pp_vld_ff, pp_vld_in;
   logic [1:0]  pp_sh_ff, pp_sh_in;
   logic [47:0] pp_ff,   pp_in;
   logic [47:0] a_ff,    a_in;
   logic [47:0] r_ff,    r_in;
   logic        neg_ff,  neg_in;
   logic [95:0] acc_ff,  acc_in;
   logic [47:0] res_ff,  res_in;

   logic [23:0] a_sel;
   logic [23:0] r_sel;
   logic [95:0] pp_wide;
   logic [63:0] mag;

   always_comb begin
      run_in    = run_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      pp_vld_in = 1'b0;
      pp_sh_in  = 2'd0;
      a_in      = a_ff;
      r_in      = r_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      a_sel     = a_ff[23:0];
      r_sel     = r_ff[23:0];
      pp_wide   = {48'd0, pp_ff};
      mag       = acc_ff[95:32];

      // pick the partial product for this pass
      case (step_ff)
         3'd1:    begin a_sel = a_ff[23:0];  r_sel = r_ff[47:24]; pp_sh_in = 2'd1; end
         3'd2:    begin a_sel = a_ff[47:24]; r_sel = r_ff[23:0];  pp_sh_in = 2'd1; end
         3'd3:    begin a_sel = a_ff[47:24]; r_sel = r_ff[47:24]; pp_sh_in = 2'd2; end
         default: begin a_sel = a_ff[23:0];  r_sel = r_ff[23:0];  pp_sh_in = 2'd0; end
      endcase
      pp_in = {24'd0, a_sel} * {24'd0, r_sel};

      case (pp_sh_ff)
         2'd1:    pp_wide = {24'd0, pp_ff, 24'd0};
         2'd2:    pp_wide = {pp_ff, 48'd0};
         default: pp_wide = {48'd0, pp_ff};
      endcase

      if (mul_cmd.start) begin
         run_in  = 1'b1;
         step_in = 3'd0;
         neg_in  = mul_cmd.amount[47] ^ mul_cmd.rate_value[47];
         a_in    = mul_cmd.amount[47] ? 48'(-mul_cmd.amount) : mul_cmd.amount;
         r_in    = mul_cmd.rate_value[47] ? 48'(-mul_cmd.rate_value) : mul_cmd.rate_value;
         // seed with the rounding bias: half of the dropped 32 bits
         acc_in  = 96'h8000_0000;
      end else if (run_ff) begin
         step_in   = step_ff + 3'd1;
         pp_vld_in = (step_ff < 3'd4);
         if (pp_vld_ff) begin
            acc_in = acc_ff + pp_wide;
         end
         if (step_ff == 3'd5) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            if (neg_ff) begin
               res_in = (mag >= {16'd0, krt_pkg::SAT_MIN}) ? krt_pkg::SAT_MIN
                                                           : 48'(~mag + 64'd1);
            end else begin
               res_in = (mag > {16'd0, krt_pkg::SAT_MAX}) ? krt_pkg::SAT_MAX
                                                          : mag[47:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         done_ff   <= 1'b0;
         pp_vld_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         done_ff   <= done_in;
         pp_vld_ff <= pp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      pp_sh_ff <= pp_sh_in;
      pp_ff    <= pp_in;
      a_ff     <= a_in;
      r_ff     <= r_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
   end

   assign mul_rsp.done  = done_ff;
   assign mul_rsp.value = res_ff;

endmodule
`default_nettype wire

// ===== rtl/krt_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_seq: transaction sequencer
// Scans the table for a key, applies upserts, starts the scaler and holds
// the response register.
// ----------------------------------------------------------------------------
module krt_seq (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  krt_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output krt_pkg::rsp_type       rsp_payload,
   output krt_pkg::store_cmd_type store_cmd,
   input  krt_pkg::entry_type     rd_data,
   output krt_pkg::mul_cmd_type   mul_cmd,
   input  krt_pkg::mul_rsp_type   mul_rsp
);

   krt_pkg::state_type               state_ff,    state_in;
   krt_pkg::req_type                 item_ff,     item_in;
   logic [krt_pkg::CNT_W-1:0]        issue_ff,    issue_in;
   logic                             pend_ff,     pend_in;
   logic [krt_pkg::IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                             hit_ff,      hit_in;
   logic [krt_pkg::IDX_W-1:0]        hit_idx_ff,  hit_idx_in;
   krt_pkg::entry_type               hit_rec_ff,  hit_rec_in;
   krt_pkg::status_type              status_ff,   status_in;
   logic signed [47:0]               conv_ff,     conv_in;
   logic signed [47:0]               rrate_ff,    rrate_in;
   logic [47:0]                      rtime_ff,    rtime_in;
   logic [krt_pkg::CNT_W-1:0]        used_ff,     used_in;
   logic [31:0]                      rev_ff,      rev_in;
   logic                             rsp_vld_ff,  rsp_vld_in;
   krt_pkg::rsp_type                 rsp_ff,      rsp_in;

   logic key_match;

   assign key_match = (rd_data.base_code == item_ff.base_code) &&
                      (rd_data.quote_code == item_ff.quote_code);

   always_comb begin
      state_in    = state_ff;
      item_in     = item_ff;
      issue_in    = issue_ff;
      pend_in     = 1'b0;
      pend_idx_in = issue_ff[krt_pkg::IDX_W-1:0];
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rec_in  = hit_rec_ff;
      status_in   = status_ff;
      conv_in     = conv_ff;
      rrate_in    = rrate_ff;
      rtime_in    = rtime_ff;
      used_in     = used_ff;
      rev_in      = rev_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_in      = rsp_ff;

      store_cmd.rd_en              = 1'b0;
      store_cmd.rd_addr            = issue_ff[krt_pkg::IDX_W-1:0];
      store_cmd.wr_en              = 1'b0;
      store_cmd.wr_addr            = hit_idx_ff;
      store_cmd.wr_data.base_code  = item_ff.base_code;
      store_cmd.wr_data.quote_code = item_ff.quote_code;
      store_cmd.wr_data.rate_value = item_ff.rate_value;
      store_cmd.wr_data.event_time = item_ff.event_time;

      mul_cmd.start      = 1'b0;
      mul_cmd.amount     = item_ff.amount;
      mul_cmd.rate_value = hit_rec_ff.rate_value;

      req_stall = (state_ff != krt_pkg::ST_IDLE);

      unique case (state_ff)
         krt_pkg::ST_IDLE: begin
            if (req_valid) begin
               item_in   = req_payload;
               status_in = krt_pkg::STATUS_OK;
               conv_in   = '0;
               rrate_in  = '0;
               rtime_in  = '0;
               issue_in  = '0;
               hit_in    = 1'b0;
               state_in  = krt_pkg::ST_SCAN;
               unique case (req_payload.kind)
                  krt_pkg::KIND_UPSERT: begin
                     if (req_payload.base_code == 24'd0 || req_payload.quote_code == 24'd0 ||
                         req_payload.rate_value[47] || req_payload.rate_value == 48'sd0) begin
                        status_in = krt_pkg::STATUS_INVALID;
                        state_in  = krt_pkg::ST_RESP;
                     end
                  end
                  krt_pkg::KIND_FIND: begin
                     state_in = krt_pkg::ST_SCAN;
                  end
                  krt_pkg::KIND_CONVERT: begin
                     if (req_payload.base_code == req_payload.quote_code) begin
                        conv_in  = req_payload.amount;
                        state_in = krt_pkg::ST_RESP;
                     end
                  end
                  default: begin
                     status_in = krt_pkg::STATUS_INVALID;
                     state_in  = krt_pkg::ST_RESP;
                  end
               endcase
            end
         end

         krt_pkg::ST_SCAN: begin
            // issue one read a cycle, compare the one issued last cycle
            if (issue_ff < used_ff) begin
               store_cmd.rd_en = 1'b1;
               issue_in        = issue_ff + krt_pkg::CNT_W'(1);
               pend_in         = 1'b1;
            end
            if (pend_ff && key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               hit_rec_in = rd_data;
               state_in   = krt_pkg::ST_DECIDE;
            end else if (!pend_ff && issue_ff >= used_ff) begin
               state_in = krt_pkg::ST_DECIDE;
            end
         end

         krt_pkg::ST_DECIDE: begin
            state_in = krt_pkg::ST_RESP;
            unique case (item_ff.kind)
               krt_pkg::KIND_UPSERT: begin
                  if (hit_ff) begin
                     if (item_ff.event_time < hit_rec_ff.event_time) begin
                        status_in = krt_pkg::STATUS_STALE;
                     end else begin
                        store_cmd.wr_en = 1'b1;
                        rev_in          = rev_ff + 32'd1;
                     end
                  end else if (used_ff >= krt_pkg::CAP_CNT) begin
                     status_in = krt_pkg::STATUS_FULL;
                  end else begin
                     store_cmd.wr_en   = 1'b1;
                     store_cmd.wr_addr = used_ff[krt_pkg::IDX_W-1:0];
                     used_in           = used_ff + krt_pkg::CNT_W'(1);
                     rev_in            = rev_ff + 32'd1;
                  end
               end
               krt_pkg::KIND_FIND: begin
                  if (hit_ff) begin
                     rrate_in = hit_rec_ff.rate_value;
                     rtime_in = hit_rec_ff.event_time;
                  end else begin
                     status_in = krt_pkg::STATUS_NOT_FOUND;
                  end
               end
               krt_pkg::KIND_CONVERT: begin
                  if (hit_ff) begin
                     mul_cmd.start = 1'b1;
                     state_in      = krt_pkg::ST_MUL;
                  end else begin
                     status_in = krt_pkg::STATUS_NOT_FOUND;
                  end
               end
               default: begin
                  status_in = krt_pkg::STATUS_INVALID;
               end
            endcase
         end

         krt_pkg::ST_MUL: begin
            if (mul_rsp.done) begin
               conv_in  = mul_rsp.value;
               state_in = krt_pkg::ST_RESP;
            end
         end

         krt_pkg::ST_RESP: begin
            // hold until the response register is free
            if (!rsp_vld_ff || !rsp_stall) begin
               rsp_vld_in              = 1'b1;
               rsp_in.status           = status_ff;
               rsp_in.converted_amount = conv_ff;
               rsp_in.record_rate      = rrate_ff;
               rsp_in.record_time      = rtime_ff;
               rsp_in.revision_number  = rev_ff;
               rsp_in.entry_count      = used_ff;
               state_in                = krt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = krt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= krt_pkg::ST_IDLE;
         pend_ff    <= 1'b0;
         hit_ff     <= 1'b0;
         used_ff    <= '0;
         rev_ff     <= 32'd1;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         hit_ff     <= hit_in;
         used_ff    <= used_in;
         rev_ff     <= rev_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      issue_ff    <= issue_in;
      pend_idx_ff <= pend_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rec_ff  <= hit_rec_in;
      status_ff   <= status_in;
      conv_ff     <= conv_in;
      rrate_ff    <= rrate_in;
      rtime_ff    <= rtime_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/krt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_checker: port-level checks for the rate table
// Watches the top level ports only; attached through bind.
// ----------------------------------------------------------------------------
module krt_checker (
   input wire              clock,
   input wire              reset,
   input wire              req_valid,
   input wire              req_stall,
   input wire              rsp_valid,
   input wire              rsp_stall,
   input krt_pkg::rsp_type rsp_payload
);

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Drop the response valid out of reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Block further transactions while one is in flight.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   // Failed transactions carry no record.
   a_no_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != krt_pkg::STATUS_OK |->
      rsp_payload.record_rate == 48'sd0 && rsp_payload.record_time == 48'd0)
      else $error("record fields set on failure");

   // A missed lookup yields a zero converted amount.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == krt_pkg::STATUS_NOT_FOUND |->
      rsp_payload.converted_amount == 48'sd0)
      else $error("converted amount set on miss");

endmodule

bind keyed_rate_table_convert krt_checker u_krt_checker (.*);
`default_nettype wire

// ===== tb/sv/keyed_rate_table_convert_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_rate_table_convert_tb: self-checking bench for the keyed rate table
// Sends upsert, find and convert transactions through the valid/stall
// channels. A shadow copy of the table predicts every response, and each
// response is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module keyed_rate_table_convert_tb;
   import krt_pkg::*;

   // The kind field has one encoding that the block must reject.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic signed [47:0] RATE_ONE      = 48'h0001_0000_0000;
   localparam logic signed [47:0] RATE_ONE_HALF = 48'h0001_8000_0000;

   // -------------------------------------------------------------------------
   // Shadow of the rate table: keeps its own entries, entry count and
   // revision, and the queue of responses still owed by the block.
   // -------------------------------------------------------------------------
   class rate_table_shadow;
      entry_type   entries [CAPACITY];
      int          used;
      logic [31:0] revision;
      rsp_type     awaited_replies [$];
      int          errors;
      int          replies;
      int          status_count [5];
      int          saturated;
      bit          hit_limit;

      function new();
         used      = 0;
         revision  = 32'd1;
         errors    = 0;
         replies   = 0;
         saturated = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function int lookup_pair(logic [23:0] base, logic [23:0] quote);
         for (int i = 0; i < used; i++)
            if (entries[i].base_code == base && entries[i].quote_code == quote)
               return i;
         return -1;
      endfunction

      // Q32.16 amount times Q16.32 rate: exact product, shift by 32 with
      // rounding half away from zero on the magnitude, then saturate.
      function logic signed [47:0] scale_amount(logic signed [47:0] amt,
                                                logic signed [47:0] rate);
         logic        neg;
         logic [47:0] amt_mag;
         logic [47:0] rate_mag;
         logic [95:0] product;
         logic [63:0] mag;
         neg       = amt[47] ^ rate[47];
         amt_mag   = amt[47] ? (~amt + 48'd1) : amt;
         rate_mag  = rate[47] ? (~rate + 48'd1) : rate;
         product   = amt_mag * rate_mag;
         product   = product + 96'h8000_0000;
         mag       = product[95:32];
         hit_limit = 1'b0;
         if (neg) begin
            if (mag >= 64'h8000_0000_0000) begin
               hit_limit = 1'b1;
               return SAT_MIN;
            end
            return ~mag[47:0] + 48'd1;
         end
         if (mag > 64'h7FFF_FFFF_FFFF) begin
            hit_limit = 1'b1;
            return SAT_MAX;
         end
         return mag[47:0];
      endfunction

      function void note_request(req_type req);
         rsp_type reply;
         int      idx;
         reply        = '0;
         reply.status = STATUS_OK;
         case (req.kind)
            KIND_UPSERT: begin
               if (req.base_code == '0 || req.quote_code == '0 ||
                   req.rate_value == '0 || req.rate_value[47]) begin
                  reply.status = STATUS_INVALID;
               end else begin
                  idx = lookup_pair(req.base_code, req.quote_code);
                  if (idx >= 0) begin
                     // Equal time still replaces; only an older one is refused.
                     if (req.event_time < entries[idx].event_time) begin
                        reply.status = STATUS_STALE;
                     end else begin
                        entries[idx].rate_value = req.rate_value;
                        entries[idx].event_time = req.event_time;
                        revision = revision + 32'd1;
                     end
                  end else if (used >= CAPACITY) begin
                     reply.status = STATUS_FULL;
                  end else begin
                     entries[used] = '{req.base_code, req.quote_code,
                                       req.rate_value, req.event_time};
                     used     = used + 1;
                     revision = revision + 32'd1;
                  end
               end
            end
            KIND_FIND: begin
               idx = lookup_pair(req.base_code, req.quote_code);
               if (idx >= 0) begin
                  reply.record_rate = entries[idx].rate_value;
                  reply.record_time = entries[idx].event_time;
               end else begin
                  reply.status = STATUS_NOT_FOUND;
               end
            end
            KIND_CONVERT: begin
               // Equal codes pass the amount through without any lookup.
               if (req.base_code == req.quote_code) begin
                  reply.converted_amount = req.amount;
               end else begin
                  idx = lookup_pair(req.base_code, req.quote_code);
                  if (idx >= 0) begin
                     reply.converted_amount =
                        scale_amount(req.amount, entries[idx].rate_value);
                     if (hit_limit) saturated++;
                  end else begin
                     reply.status = STATUS_NOT_FOUND;
                  end
               end
            end
            default: reply.status = STATUS_INVALID;
         endcase
         reply.revision_number = revision;
         reply.entry_count     = CNT_W'(used);
         awaited_replies.push_back(reply);
      endfunction

      function void compare_field(string field_name, logic [63:0] want,
                                  logic [63:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t %s mismatch: expected %h, actual %h",
                     $time, field_name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         replies++;
         if (awaited_replies.size() == 0) begin
            errors++;
            $display("%0t response with none outstanding: expected nothing, actual %h",
                     $time, got);
            return;
         end
         want = awaited_replies.pop_front();
         status_count[int'(want.status)]++;
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("converted_amount", 64'(want.converted_amount),
                       64'(got.converted_amount));
         compare_field("record_rate", 64'(want.record_rate), 64'(got.record_rate));
         compare_field("record_time", 64'(want.record_time), 64'(got.record_time));
         compare_field("revision_number", 64'(want.revision_number),
                       64'(got.revision_number));
         compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;

   rate_table_shadow shadow;
   int               sender_idle_pct;
   int               receiver_stall_pct;
   logic [47:0]      next_time;

   keyed_rate_table_convert dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: check the transaction that completes at this edge, then
   // pick the stall level for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) shadow.check_response(rsp_payload);
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [23:0] currency(int idx);
      case (idx)
         0:       return "USD";
         1:       return "EUR";
         2:       return "JPY";
         3:       return "GBP";
         default: return "CHF";
      endcase
   endfunction

   // Twenty ordered pairs of distinct currencies; more than the table holds.
   function automatic logic [47:0] pool_pair(int k);
      int base_idx;
      int quote_idx;
      base_idx  = k / 4;
      quote_idx = k % 4;
      if (quote_idx >= base_idx) quote_idx = quote_idx + 1;
      return {currency(base_idx), currency(quote_idx)};
   endfunction

   function automatic logic [47:0] random48();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[47:0];
   endfunction

   function automatic req_type make_request(logic [1:0] kind, logic [23:0] base,
                                            logic [23:0] quote,
                                            logic signed [47:0] rate,
                                            logic [47:0] stamp,
                                            logic signed [47:0] amt);
      req_type req;
      req.kind       = kind;
      req.base_code  = base;
      req.quote_code = quote;
      req.rate_value = rate;
      req.event_time = stamp;
      req.amount     = amt;
      return req;
   endfunction

   // Mostly well-formed traffic on the pair pool, with a share of odd codes,
   // bad rates, older times and the unused kind.
   function automatic req_type random_request();
      req_type     req;
      int          pick;
      logic [47:0] pair;
      logic [47:0] bits;
      pick = $urandom_range(0, 99);
      if (pick < 35)      req.kind = KIND_UPSERT;
      else if (pick < 60) req.kind = KIND_FIND;
      else if (pick < 95) req.kind = KIND_CONVERT;
      else                req.kind = KIND_UNUSED;

      pick = $urandom_range(0, 99);
      pair = pool_pair($urandom_range(0, 19));
      bits = random48();
      if (pick < 80) begin
         req.base_code  = pair[47:24];
         req.quote_code = pair[23:0];
      end else if (pick < 88) begin
         req.base_code  = ($urandom_range(0, 3) == 0) ? 24'd0 : bits[23:0];
         req.quote_code = req.base_code;
      end else if (pick < 95) begin
         req.base_code  = bits[47:24];
         req.quote_code = bits[23:0];
      end else if ($urandom_range(0, 1) == 0) begin
         req.base_code  = 24'd0;
         req.quote_code = pair[23:0];
      end else begin
         req.base_code  = pair[47:24];
         req.quote_code = 24'd0;
      end

      pick = $urandom_range(0, 99);
      if (req.kind != KIND_UPSERT) begin
         req.rate_value = random48();
      end else if (pick < 40) begin
         req.rate_value = random48() & 48'h0003_FFFF_FFFF;
         if (req.rate_value == '0) req.rate_value = RATE_ONE;
      end else if (pick < 80) begin
         req.rate_value     = random48();
         req.rate_value[47] = 1'b0;
         if (req.rate_value == '0) req.rate_value = SAT_MAX;
      end else if (pick < 90) begin
         req.rate_value = '0;
      end else begin
         req.rate_value     = random48();
         req.rate_value[47] = 1'b1;
      end

      // Upsert times creep forward and now and then step back.
      if (req.kind == KIND_UPSERT) begin
         next_time      = next_time + 48'($urandom_range(0, 4));
         req.event_time = next_time;
         if ($urandom_range(0, 3) == 0)
            req.event_time = next_time - 48'($urandom_range(0, 12));
      end else begin
         req.event_time = random48();
      end

      pick = $urandom_range(0, 99);
      bits = random48();
      if (pick < 50) begin
         req.amount = bits;
      end else if (pick < 80) begin
         req.amount = {{24{bits[23]}}, bits[23:0]};
      end else begin
         case ($urandom_range(0, 4))
            0:       req.amount = SAT_MAX;
            1:       req.amount = SAT_MIN;
            2:       req.amount = '0;
            3:       req.amount = '1;
            default: req.amount = 48'd1;
         endcase
      end
      return req;
   endfunction

   // Offer one transaction, hold it until taken, then maybe idle the sender.
   task automatic send_request(input req_type req);
      int gap;
      req_payload <= req;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.note_request(req);
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted response has come back,
   // plus a margin for the block's own latency.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (shadow.awaited_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      logic [47:0] pair;
      int          sent;
      int          k;
      int          phase;
      shadow             = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_payload        = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      next_time          = 48'd1000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: lookups on an empty table, pass-through converts, every
      // rejection rule, stale and equal times, rounding and both saturations.
      send_request(make_request(KIND_FIND, "USD", "EUR", '0, '0, '0));
      send_request(make_request(KIND_CONVERT, "USD", "EUR", '0, '0, 48'd1));
      send_request(make_request(KIND_CONVERT, "USD", "USD", '1, '1, SAT_MAX));
      send_request(make_request(KIND_CONVERT, 24'd0, 24'd0, '0, '0, SAT_MIN));
      send_request(make_request(KIND_UNUSED, '1, '1, SAT_MAX, '1, '1));
      send_request(make_request(KIND_UPSERT, 24'd0, "EUR", RATE_ONE, 48'd5, '0));
      send_request(make_request(KIND_UPSERT, "USD", 24'd0, RATE_ONE, 48'd5, '0));
      send_request(make_request(KIND_UPSERT, "USD", "EUR", '0, 48'd5, '0));
      send_request(make_request(KIND_UPSERT, "USD", "EUR", SAT_MIN, 48'd5, '0));
      send_request(make_request(KIND_UPSERT, "USD", "EUR", RATE_ONE, 48'd100, '0));
      send_request(make_request(KIND_UPSERT, "USD", "EUR", RATE_ONE, 48'd99, '0));
      send_request(make_request(KIND_UPSERT, "USD", "EUR", RATE_ONE_HALF, 48'd100, '0));
      send_request(make_request(KIND_FIND, "USD", "EUR", '0, '0, '0));
      send_request(make_request(KIND_CONVERT, "USD", "EUR", '0, '0, SAT_MAX));
      send_request(make_request(KIND_CONVERT, "USD", "EUR", '0, '0, SAT_MIN));
      send_request(make_request(KIND_CONVERT, "USD", "EUR", '0, '0, '1));
      send_request(make_request(KIND_UPSERT, "EUR", "USD", SAT_MAX, '1, '0));
      send_request(make_request(KIND_CONVERT, "EUR", "USD", '0, '0, 48'd1));

      // Fill the table with fresh pairs; the last one finds it full.
      sent = 0;
      for (k = 1; k < 20 && sent < 15; k++) begin
         if (k != 4) begin
            pair = pool_pair(k);
            send_request(make_request(KIND_UPSERT, pair[47:24], pair[23:0],
                                      RATE_ONE + 48'(k), 48'd500, '0));
            sent++;
         end
      end
      // Hold the sender until the table has answered everything so far.
      drain_replies();

      // Random traffic under four handshake pressure profiles.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
            default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
         endcase
         repeat (238) send_request(random_request());
         drain_replies();
      end
      receiver_stall_pct = 0;

      $display("Checked %0d responses: %0d ok, %0d invalid, %0d stale, %0d full, %0d not found",
               shadow.replies, shadow.status_count[0], shadow.status_count[1],
               shadow.status_count[2], shadow.status_count[3], shadow.status_count[4]);
      $display("%0d converts hit a saturation limit; table ends with %0d pairs, revision %0d",
               shadow.saturated, shadow.used, shadow.revision);
      if (shadow.errors == 0 && shadow.awaited_replies.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/krt_pkg.sv
rtl/krt_store.sv
rtl/krt_mul.sv
rtl/krt_seq.sv
rtl/keyed_rate_table_convert.sv
rtl/krt_checker.sv
tb/sv/keyed_rate_table_convert_tb.sv
